// File: hdl/prfl_pkg.sv
`default_nettype none

package prfl_pkg;

    localparam int FRAME_DEPTH = 8;
    localparam int PAGE_BITS   = 8;
    localparam int IDX_W       = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_LRU_MODE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = CFG_IDX_W'(1);
    localparam logic [CFG_DATA_W-1:0] FRAMES_RESET     = CFG_DATA_W'(8);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_SHIFT,
        S_DRAIN,
        S_FILL
    } t_state;

endpackage

`default_nettype wire

// File: hdl/page_replacement_fifo_lru.sv
// each item: search walks slots 0..n-1 (n = frames in use), then the decide state registers the result;
//   a fifo hit returns to idle there, otherwise a shift walk moves slots from+1..n-1 down by one and fill
//   writes the new page into slot n-1; from = slot of the hit page (lru) or 0 (miss)
// busy is high while the state machine is out of idle; start is ignored while busy
// receiver cannot stall: each result is shown for exactly one cycle
// reset (synchronous, active low): list empty, fifo mode, 8 frames in use
`default_nettype none

module page_replacement_fifo_lru (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // access channel
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [prfl_pkg::PAGE_BITS-1:0]     i_page,
    // result channel
    output logic                                    o_result_valid,
    output logic                                    o_hit,
    output logic                                    o_victim_valid,
    output logic [prfl_pkg::PAGE_BITS-1:0]          o_victim_page,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [prfl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [prfl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DEPTH = prfl_pkg::FRAME_DEPTH;
    localparam int PB    = prfl_pkg::PAGE_BITS;
    localparam int IW    = prfl_pkg::IDX_W;

    // configuration registers
    logic                              r_lru_mode;
    logic [prfl_pkg::CFG_DATA_W-1:0]   r_frames;

    // page store: one entry per frame slot, oldest at slot 0
    logic [PB-1:0]      mem_pages [DEPTH];
    logic [PB-1:0]      r_rd_data;
    // valid bits live in flops so reset empties the list at once
    logic [DEPTH-1:0]   r_valid;

    prfl_pkg::t_state   r_state, n_state;

    // item context
    logic [PB-1:0]      r_page;
    logic               r_mode;
    logic [IW-1:0]      r_last;      // n-1, last slot in use
    logic [IW-1:0]      r_idx;       // memory read address (search and shift walk)

    // search pipeline: compare runs in the cycle after the read
    logic               r_cmp_vld;
    logic [IW-1:0]      r_cmp_idx;
    logic               r_found;
    logic [IW-1:0]      r_where;
    logic [PB-1:0]      r_vp;        // page held in slot 0

    // shift pipeline: data read at slot j is written to slot j-1 in the following cycle
    logic               r_sh_vld;
    logic [IW-1:0]      r_sh_dst;

    // result registers
    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_vv;
    logic [PB-1:0]      r_out_vp;

    // combinational
    logic               accept;
    logic               cur_match;
    logic               found_now;
    logic [IW-1:0]      where_now;
    logic [PB-1:0]      vp_now;
    logic               do_update;
    logic [IW-1:0]      from_slot;
    logic [IW-1:0]      n_last;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [PB-1:0]      wr_data;

    assign busy        = (r_state != prfl_pkg::S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign o_result_valid = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_victim_valid = r_out_vv;
    assign o_victim_page  = r_out_vp;

    // saturate frames in use to 1..DEPTH, kept as the index of the last slot
    always_comb begin
        if (r_frames == '0) begin
            n_last = '0;
        end else if (32'(r_frames) > DEPTH) begin
            n_last = IW'(DEPTH - 1);
        end else begin
            n_last = IW'(r_frames - 1'b1);
        end
    end

    // an empty slot never matches
    assign cur_match = r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_data == r_page);

    // final search outcome, valid in the decide state where the last compare lands
    assign found_now = r_found || cur_match;
    assign where_now = r_found ? r_where : r_cmp_idx;
    assign vp_now    = (r_cmp_idx == '0) ? r_rd_data : r_vp;

    // a fifo hit leaves the list untouched; otherwise close the gap from here
    assign do_update = !found_now || r_mode;
    assign from_slot = found_now ? where_now : '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prfl_pkg::S_IDLE: begin
                if (start) n_state = prfl_pkg::S_SEARCH;
            end
            prfl_pkg::S_SEARCH: begin
                if (r_idx == r_last) n_state = prfl_pkg::S_DECIDE;
            end
            prfl_pkg::S_DECIDE: begin
                if (!do_update) begin
                    n_state = prfl_pkg::S_IDLE;
                end else if (from_slot == r_last) begin
                    n_state = prfl_pkg::S_FILL;
                end else begin
                    n_state = prfl_pkg::S_SHIFT;
                end
            end
            prfl_pkg::S_SHIFT: begin
                if (r_idx == r_last) n_state = prfl_pkg::S_DRAIN;
            end
            prfl_pkg::S_DRAIN: n_state = prfl_pkg::S_FILL;
            prfl_pkg::S_FILL:  n_state = prfl_pkg::S_IDLE;
            default:           n_state = prfl_pkg::S_IDLE;
        endcase
    end

    // write port: pending shift write, or the new page into the last slot
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_sh_dst;
        wr_data = r_rd_data;
        if (r_sh_vld) begin
            wr_en = 1'b1;
        end else if (r_state == prfl_pkg::S_FILL) begin
            wr_en   = 1'b1;
            wr_addr = r_last;
            wr_data = r_page;
        end
    end

    // page memory, one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) mem_pages[wr_addr] <= wr_data;
        r_rd_data <= mem_pages[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prfl_pkg::S_IDLE;
            r_lru_mode  <= 1'b0;
            r_frames    <= prfl_pkg::FRAMES_RESET;
            r_valid     <= '0;
            r_cmp_vld   <= 1'b0;
            r_sh_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= (r_state == prfl_pkg::S_SEARCH);
            r_sh_vld    <= (r_state == prfl_pkg::S_SHIFT);
            r_out_valid <= 1'b0;

            if (i_cfg_valid) begin
                if (i_cfg_index == prfl_pkg::CFG_LRU_MODE) begin
                    r_lru_mode <= i_cfg_data[0];
                end else if (i_cfg_index == prfl_pkg::CFG_FRAMES_IN_USE) begin
                    r_frames <= i_cfg_data;
                end
            end

            // search bookkeeping, first match wins
            if (r_state == prfl_pkg::S_SEARCH && cur_match && !r_found) begin
                r_found <= 1'b1;
            end

            // valid bits follow the page moves
            if (r_sh_vld) begin
                r_valid[r_sh_dst] <= r_valid[IW'(r_sh_dst + 1'b1)];
            end else if (r_state == prfl_pkg::S_FILL) begin
                r_valid[r_last] <= 1'b1;
            end

            unique case (r_state)
                prfl_pkg::S_IDLE: begin
                    if (accept) begin
                        r_idx   <= '0;
                        r_found <= 1'b0;
                    end
                end
                prfl_pkg::S_SEARCH, prfl_pkg::S_SHIFT: begin
                    if (r_idx != r_last) r_idx <= IW'(r_idx + 1'b1);
                end
                prfl_pkg::S_DECIDE: begin
                    r_out_valid <= 1'b1;
                    r_idx       <= IW'(from_slot + 1'b1);
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= i_page;
            r_mode <= r_lru_mode;
            r_last <= n_last;
        end
        r_cmp_idx <= r_idx;
        r_sh_dst  <= IW'(r_idx - 1'b1);
        if (r_cmp_vld && r_cmp_idx == '0) r_vp <= r_rd_data;
        if (r_state == prfl_pkg::S_SEARCH && cur_match && !r_found) r_where <= r_cmp_idx;
        if (r_state == prfl_pkg::S_DECIDE) begin
            r_out_hit <= found_now;
            r_out_vv  <= !found_now && r_valid[0];
            r_out_vp  <= (!found_now && r_valid[0]) ? vp_now : '0;
        end
    end

`ifndef SYNTHESIS
    // a result is only issued from the decide step
    a_result_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == prfl_pkg::S_DECIDE))
        else $error("result strobe without a finished search");

    // an accepted item makes the block busy, at least until its decide step
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("block not busy after accepting an item");

    // a hit never reports an eviction
    a_hit_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_hit) |-> (!o_victim_valid && o_victim_page == '0))
        else $error("hit reported together with a victim");

    // the shift pipeline is empty before the new page is written
    a_fill_no_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prfl_pkg::S_FILL) |-> (!r_sh_vld && !r_cmp_vld))
        else $error("fill overlaps a pending move");
`endif

endmodule

`default_nettype wire
